// File: rtl/rgdg_pkg.sv
package rgdg_pkg;

	localparam int MAX_POINTS    = 1024;
	localparam int CORDIC_STAGES = 16;

	localparam int AP_W  = 16;
	localparam int CNT_W = 11;
	localparam int IDX_W = 10;
	localparam int DIR_W = 16;
	localparam int ANG_W = 32;
	localparam int XY_W  = 33;

	// quotient of the grid division fits 30 bits, taken two bits a stage
	localparam int QUO_W      = 30;
	localparam int DIV_STEP   = 2;
	localparam int DIV_STAGES = QUO_W / DIV_STEP;

	localparam logic signed [ANG_W-1:0] HALF_PI = 32'sd421657428;
	localparam logic signed [ANG_W-1:0] PI      = 32'sd843314857;
	localparam logic signed [XY_W-1:0]  GAIN    = 33'sd652032874;
	localparam int Q14_ONE = 16384;

	localparam logic [1:0] REG_HORIZ_APERTURE = 2'd0;
	localparam logic [1:0] REG_VERT_APERTURE  = 2'd1;
	localparam logic [1:0] REG_HORIZ_COUNT    = 2'd2;
	localparam logic [1:0] REG_VERT_COUNT     = 2'd3;

	typedef struct packed {
		logic vld;
		logic err;
	} ctl_t;

	function automatic logic signed [ANG_W-1:0] atan_entry(input int i);
		case (i)
			0: atan_entry = 32'sd210828714;
			1: atan_entry = 32'sd124459457;
			2: atan_entry = 32'sd65760959;
			3: atan_entry = 32'sd33381290;
			4: atan_entry = 32'sd16755422;
			5: atan_entry = 32'sd8385879;
			6: atan_entry = 32'sd4193963;
			7: atan_entry = 32'sd2097109;
			8: atan_entry = 32'sd1048571;
			9: atan_entry = 32'sd524287;
			10: atan_entry = 32'sd262144;
			11: atan_entry = 32'sd131072;
			12: atan_entry = 32'sd65536;
			13: atan_entry = 32'sd32768;
			14: atan_entry = 32'sd16384;
			15: atan_entry = 32'sd8192;
			16: atan_entry = 32'sd4096;
			17: atan_entry = 32'sd2048;
			18: atan_entry = 32'sd1024;
			19: atan_entry = 32'sd512;
			20: atan_entry = 32'sd256;
			21: atan_entry = 32'sd128;
			22: atan_entry = 32'sd64;
			23: atan_entry = 32'sd32;
			default: atan_entry = '0;
		endcase
	endfunction

	function automatic logic signed [DIR_W-1:0] clamp_q14(input logic signed [17:0] v);
		if (v > 18'sd16384)
			clamp_q14 = 16'sd16384;
		else if (v < -18'sd16384)
			clamp_q14 = -16'sd16384;
		else
			clamp_q14 = v[DIR_W-1:0];
	endfunction

endpackage

// File: rtl/rgdg_in_if.sv
interface rgdg_in_if;
	logic                         valid;
	logic                         ready;
	logic [rgdg_pkg::IDX_W-1:0]   column_index;
	logic [rgdg_pkg::IDX_W-1:0]   row_index;

	modport source(output valid, column_index, row_index, input ready);
	modport sink(input valid, column_index, row_index, output ready);
endinterface

// File: rtl/rgdg_out_if.sv
interface rgdg_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [rgdg_pkg::DIR_W-1:0]  dir_x;
	logic signed [rgdg_pkg::DIR_W-1:0]  dir_y;
	logic signed [rgdg_pkg::DIR_W-1:0]  dir_z;
	logic                               index_error;

	modport source(output valid, dir_x, dir_y, dir_z, index_error, input ready);
	modport sink(input valid, dir_x, dir_y, dir_z, index_error, output ready);
endinterface

// File: rtl/rgdg_angle.sv
// Grid angle in 2^-28 rad: multiply, then a radix-4 restoring divider by (count-1).
module rgdg_angle (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  logic                               in_vld,
	input  logic [rgdg_pkg::IDX_W-1:0]         idx,
	input  logic [rgdg_pkg::AP_W-1:0]          ap,
	input  logic [rgdg_pkg::CNT_W-1:0]         count,
	output rgdg_pkg::ctl_t                     out_ctl,
	output logic signed [rgdg_pkg::ANG_W-1:0]  angle
);
	localparam int DS = rgdg_pkg::DIV_STAGES;
	localparam int QW = rgdg_pkg::QUO_W;

	logic [rgdg_pkg::CNT_W-1:0] n_eff;
	logic                       single;
	logic [9:0]                 d_c;
	logic signed [11:0]         k_c;
	logic [10:0]                absk_c;
	logic                       neg_c;

	logic [rgdg_pkg::AP_W-1:0]  ap_s1;
	logic [9:0]                 d_s1, d_s2;
	logic [10:0]                absk_s1;
	logic                       neg_s1, neg_s2;
	rgdg_pkg::ctl_t             ctl_s1, ctl_s2;
	logic [26:0]                m_s2;

	logic [40:0]                num_c;

	logic [9:0]                 rem_s [0:DS];
	logic [QW-1:0]              low_s [0:DS];
	logic [9:0]                 dv_s  [0:DS];
	logic                       neg_s [0:DS];
	rgdg_pkg::ctl_t             ctl_s [0:DS];

	always_comb begin
		if ({2'b0, count} > 13'(rgdg_pkg::MAX_POINTS))
			n_eff = rgdg_pkg::CNT_W'(rgdg_pkg::MAX_POINTS);
		else
			n_eff = count;
		single = (n_eff <= 11'd1);
		d_c    = single ? 10'd1 : 10'(n_eff - 11'd1);
		k_c    = $signed({1'b0, idx, 1'b0}) - $signed({2'b0, d_c});
		if (single) begin
			absk_c = 11'd1;
			neg_c  = 1'b1;
		end else begin
			neg_c  = k_c[11];
			absk_c = k_c[11] ? 11'(-k_c) : k_c[10:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
		end else if (en) begin
			ctl_s1 <= '{vld: in_vld, err: ({1'b0, idx} >= n_eff)};
			ctl_s2 <= ctl_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ap_s1   <= ap;
			d_s1    <= d_c;
			absk_s1 <= absk_c;
			neg_s1  <= neg_c;
			m_s2    <= 27'(ap_s1) * 27'(absk_s1);
			d_s2    <= d_s1;
			neg_s2  <= neg_s1;
		end
	end

	// rounding half away from zero: add half the divisor to the magnitude
	assign num_c = {m_s2, 14'b0} + 41'(d_s2 >> 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s[0] <= '0;
		else if (en)
			ctl_s[0] <= ctl_s2;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			rem_s[0] <= num_c[39:30];
			low_s[0] <= num_c[29:0];
			dv_s[0]  <= d_s2;
			neg_s[0] <= neg_s2;
		end
	end

	for (genvar g = 0; g < DS; g++) begin : g_div
		logic [9:0]    rem_n;
		logic [QW-1:0] low_n;

		always_comb begin
			logic [10:0] t;
			logic        ge;
			rem_n = rem_s[g];
			low_n = low_s[g];
			for (int j = 0; j < rgdg_pkg::DIV_STEP; j++) begin
				t     = {rem_n, low_n[QW-1]};
				ge    = (t >= {1'b0, dv_s[g]});
				rem_n = ge ? 10'(t - {1'b0, dv_s[g]}) : t[9:0];
				low_n = {low_n[QW-2:0], ge};
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ctl_s[g+1] <= '0;
			else if (en)
				ctl_s[g+1] <= ctl_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[g+1] <= rem_n;
				low_s[g+1] <= low_n;
				dv_s[g+1]  <= dv_s[g];
				neg_s[g+1] <= neg_s[g];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ctl <= '0;
		else if (en)
			out_ctl <= ctl_s[DS];
	end

	always_ff @(posedge clk) begin
		if (en)
			angle <= neg_s[DS] ? -$signed({2'b0, low_s[DS]}) : $signed({2'b0, low_s[DS]});
	end

endmodule

// File: rtl/rgdg_cordic.sv
// Rotation-mode CORDIC, one micro-rotation per stage, Q1.14 sine and cosine out.
module rgdg_cordic (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               en,
	input  rgdg_pkg::ctl_t                     in_ctl,
	input  logic signed [rgdg_pkg::ANG_W-1:0]  angle,
	output rgdg_pkg::ctl_t                     out_ctl,
	output logic signed [rgdg_pkg::DIR_W-1:0]  sin_q14,
	output logic signed [rgdg_pkg::DIR_W-1:0]  cos_q14
);
	localparam int NS = rgdg_pkg::CORDIC_STAGES;

	logic signed [rgdg_pkg::XY_W-1:0]  x_s [0:NS];
	logic signed [rgdg_pkg::XY_W-1:0]  y_s [0:NS];
	logic signed [rgdg_pkg::ANG_W-1:0] z_s [0:NS];
	logic                              flip_s [0:NS];
	rgdg_pkg::ctl_t                    ctl_s [0:NS];

	logic signed [rgdg_pkg::ANG_W-1:0] z0;
	logic                              flip0;
	logic signed [rgdg_pkg::XY_W-1:0]  xf, yf, xr, yr;

	// fold angles beyond a quarter turn by pi and negate the result
	always_comb begin
		if (angle > rgdg_pkg::HALF_PI) begin
			z0    = angle - rgdg_pkg::PI;
			flip0 = 1'b1;
		end else if (angle < -rgdg_pkg::HALF_PI) begin
			z0    = angle + rgdg_pkg::PI;
			flip0 = 1'b1;
		end else begin
			z0    = angle;
			flip0 = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s[0] <= '0;
		else if (en)
			ctl_s[0] <= in_ctl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			x_s[0]    <= rgdg_pkg::GAIN;
			y_s[0]    <= '0;
			z_s[0]    <= z0;
			flip_s[0] <= flip0;
		end
	end

	for (genvar g = 0; g < NS; g++) begin : g_rot
		logic signed [rgdg_pkg::XY_W-1:0] dx, dy;

		assign dx = y_s[g] >>> g;
		assign dy = x_s[g] >>> g;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n)
				ctl_s[g+1] <= '0;
			else if (en)
				ctl_s[g+1] <= ctl_s[g];
		end

		always_ff @(posedge clk) begin
			if (en) begin
				flip_s[g+1] <= flip_s[g];
				if (!z_s[g][rgdg_pkg::ANG_W-1]) begin
					x_s[g+1] <= x_s[g] - dx;
					y_s[g+1] <= y_s[g] + dy;
					z_s[g+1] <= z_s[g] - rgdg_pkg::atan_entry(g);
				end else begin
					x_s[g+1] <= x_s[g] + dx;
					y_s[g+1] <= y_s[g] - dy;
					z_s[g+1] <= z_s[g] + rgdg_pkg::atan_entry(g);
				end
			end
		end
	end

	assign xf = flip_s[NS] ? -x_s[NS] : x_s[NS];
	assign yf = flip_s[NS] ? -y_s[NS] : y_s[NS];
	assign xr = (xf + 33'sd32768) >>> 16;
	assign yr = (yf + 33'sd32768) >>> 16;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_ctl <= '0;
		else if (en)
			out_ctl <= ctl_s[NS];
	end

	always_ff @(posedge clk) begin
		if (en) begin
			cos_q14 <= rgdg_pkg::clamp_q14(xr[17:0]);
			sin_q14 <= rgdg_pkg::clamp_q14(yr[17:0]);
		end
	end

endmodule

// File: rtl/ray_grid_direction_generator.sv
// channel  dir  fields                                  accepted when
// beam     in   column_index, row_index                 valid && ready
// ray      out  dir_x, dir_y, dir_z, index_error        valid && ready
// cfg      in   cfg_index, cfg_data                     cfg_write
//
// One word enters every cycle while the output is not stalled. The grid angle
// passes the multiply registers, a register that loads the divider, 15 divider
// stages at two quotient bits a stage and a sign register; the CORDIC passes
// fold, 16 rotations and round; then come the product and output registers.
// Reset clears all valid bits and sets apertures to 1 rad, counts to 1.
// A stall at the output holds every stage; nothing is dropped or repeated.
module ray_grid_direction_generator (
	input  logic                        clk,
	input  logic                        arst_n,
	rgdg_in_if.sink                     beam,
	rgdg_out_if.source                  ray,
	input  logic                        cfg_write,
	input  logic [1:0]                  cfg_index,
	input  logic [rgdg_pkg::AP_W-1:0]   cfg_data
);
	logic [rgdg_pkg::AP_W-1:0]  horiz_aperture_q, vert_aperture_q;
	logic [rgdg_pkg::CNT_W-1:0] horiz_count_q, vert_count_q;
	logic                       en;

	rgdg_pkg::ctl_t                    h_ang_ctl, v_ang_ctl, h_cs_ctl, v_cs_ctl;
	logic signed [rgdg_pkg::ANG_W-1:0] h_angle, v_angle;
	logic signed [rgdg_pkg::DIR_W-1:0] sh, ch, sv, cv;

	logic signed [31:0]                px_s1, pz_s1;
	logic signed [rgdg_pkg::DIR_W-1:0] sy_s1;
	rgdg_pkg::ctl_t                    ctl_s1;
	logic signed [31:0]                rx, rz;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			horiz_aperture_q <= 16'd8192;
			vert_aperture_q  <= 16'd8192;
			horiz_count_q    <= 11'd1;
			vert_count_q     <= 11'd1;
		end else if (cfg_write) begin
			case (cfg_index)
				rgdg_pkg::REG_HORIZ_APERTURE: horiz_aperture_q <= cfg_data;
				rgdg_pkg::REG_VERT_APERTURE:  vert_aperture_q  <= cfg_data;
				rgdg_pkg::REG_HORIZ_COUNT:    horiz_count_q <= cfg_data[rgdg_pkg::CNT_W-1:0];
				rgdg_pkg::REG_VERT_COUNT:     vert_count_q  <= cfg_data[rgdg_pkg::CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// advance the whole pipe whenever the output word is empty or taken
	assign en         = !ray.valid || ray.ready;
	assign beam.ready = en;

	rgdg_angle u_h_angle (
		.clk, .arst_n, .en,
		.in_vld(beam.valid), .idx(beam.column_index),
		.ap(horiz_aperture_q), .count(horiz_count_q),
		.out_ctl(h_ang_ctl), .angle(h_angle)
	);

	rgdg_angle u_v_angle (
		.clk, .arst_n, .en,
		.in_vld(beam.valid), .idx(beam.row_index),
		.ap(vert_aperture_q), .count(vert_count_q),
		.out_ctl(v_ang_ctl), .angle(v_angle)
	);

	rgdg_cordic u_h_cordic (
		.clk, .arst_n, .en,
		.in_ctl('{vld: h_ang_ctl.vld, err: h_ang_ctl.err | v_ang_ctl.err}),
		.angle(h_angle),
		.out_ctl(h_cs_ctl), .sin_q14(sh), .cos_q14(ch)
	);

	rgdg_cordic u_v_cordic (
		.clk, .arst_n, .en,
		.in_ctl(v_ang_ctl), .angle(v_angle),
		.out_ctl(v_cs_ctl), .sin_q14(sv), .cos_q14(cv)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ctl_s1 <= '0;
		else if (en)
			ctl_s1 <= h_cs_ctl;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			px_s1 <= cv * sh;
			pz_s1 <= cv * ch;
			sy_s1 <= sv;
		end
	end

	assign rx = (px_s1 + 32'sd8192) >>> 14;
	assign rz = (pz_s1 + 32'sd8192) >>> 14;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ray.valid <= 1'b0;
		else if (en)
			ray.valid <= ctl_s1.vld;
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ray.index_error <= ctl_s1.err;
			ray.dir_x <= ctl_s1.err ? '0 : rgdg_pkg::clamp_q14(rx[17:0]);
			ray.dir_y <= ctl_s1.err ? '0 : sy_s1;
			ray.dir_z <= ctl_s1.err ? '0 : rgdg_pkg::clamp_q14(rz[17:0]);
		end
	end

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && ray.index_error |-> ray.dir_x == '0 && ray.dir_y == '0 && ray.dir_z == '0)
		else $error("error word carries a non-zero direction");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid |-> ray.dir_x <= 16'sd16384 && ray.dir_x >= -16'sd16384
			&& ray.dir_z <= 16'sd16384 && ray.dir_z >= -16'sd16384)
		else $error("direction outside Q1.14 unit range");

	a_lanes: assert property (@(posedge clk) disable iff (!arst_n)
		h_cs_ctl.vld == v_cs_ctl.vld && h_ang_ctl.vld == v_ang_ctl.vld)
		else $error("horizontal and vertical lanes out of step");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		ray.valid && !ray.ready |=> ray.valid && $stable(ray.dir_x) && $stable(ray.dir_z))
		else $error("stalled word changed");

endmodule
